[design/xte_pkg.sv]
package xte_pkg;

    localparam int CharW = 21;
    localparam int IdxW  = 4;

    // output segments, each a fixed string or the raw character
    typedef enum logic [3:0] {
        SEG_NONE,
        SEG_CLOSE,
        SEG_OPEN,
        SEG_SPLIT,
        SEG_AMP,
        SEG_LT,
        SEG_GT,
        SEG_QUOT,
        SEG_NUM9,
        SEG_NUM10,
        SEG_NUM13,
        SEG_RAW
    } t_seg;

    typedef struct packed {
        t_seg             prefix;
        t_seg             body;
        logic [CharW-1:0] ch;
    } t_job;

    localparam logic [CharW-1:0] ChAmp   = CharW'(8'h26);
    localparam logic [CharW-1:0] ChLt    = CharW'(8'h3c);
    localparam logic [CharW-1:0] ChGt    = CharW'(8'h3e);
    localparam logic [CharW-1:0] ChQuot  = CharW'(8'h22);
    localparam logic [CharW-1:0] ChBrack = CharW'(8'h5d);
    localparam logic [CharW-1:0] ChTab   = CharW'(8'h09);
    localparam logic [CharW-1:0] ChLf    = CharW'(8'h0a);
    localparam logic [CharW-1:0] ChCr    = CharW'(8'h0d);

    function automatic logic [IdxW-1:0] seg_len(input t_seg seg);
        logic [IdxW-1:0] n;
        case (seg)
            SEG_CLOSE: n = 4'd3;
            SEG_OPEN:  n = 4'd9;
            SEG_SPLIT: n = 4'd12;
            SEG_AMP:   n = 4'd5;
            SEG_LT:    n = 4'd4;
            SEG_GT:    n = 4'd4;
            SEG_QUOT:  n = 4'd6;
            SEG_NUM9:  n = 4'd4;
            SEG_NUM10: n = 4'd5;
            SEG_NUM13: n = 4'd5;
            SEG_RAW:   n = 4'd1;
            default:   n = 4'd1;
        endcase
        return n;
    endfunction

    // character at position idx of a fixed segment, counted from the left
    function automatic logic [CharW-1:0] seg_char(input t_seg seg, input logic [IdxW-1:0] idx);
        logic [95:0]     s;
        logic [IdxW-1:0] pos;
        case (seg)
            SEG_CLOSE: s = 96'("]]>");
            SEG_OPEN:  s = 96'("<![CDATA[");
            SEG_SPLIT: s = 96'("]]><![CDATA[");
            SEG_AMP:   s = 96'("&amp;");
            SEG_LT:    s = 96'("&lt;");
            SEG_GT:    s = 96'("&gt;");
            SEG_QUOT:  s = 96'("&quot;");
            SEG_NUM9:  s = 96'("&#9;");
            SEG_NUM10: s = 96'("&#10;");
            SEG_NUM13: s = 96'("&#13;");
            default:   s = '0;
        endcase
        pos = seg_len(seg) - idx - 4'd1;
        return CharW'(s[{pos, 3'b000} +: 8]);
    endfunction

endpackage

[design/xte_front.sv]
module xte_front import xte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [CharW-1:0] i_char_code,
    input  logic             i_cdata_mode,
    input  logic             i_in_literal,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_q_ready
);

    logic       r_open;
    logic [1:0] r_match;
    logic       n_open;
    logic [1:0] n_match;
    logic [1:0] match;
    logic       accept;
    logic       has_out;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign o_push  = accept && has_out;

    always_comb begin
        n_open       = r_open;
        n_match      = r_match;
        has_out      = 1'b1;
        match        = r_open ? r_match : 2'd0;
        o_job.prefix = SEG_NONE;
        o_job.body   = SEG_RAW;
        o_job.ch     = i_char_code;
        if (i_command) begin
            // close command, only emits when a section is open
            has_out    = r_open;
            o_job.body = SEG_CLOSE;
            n_open     = 1'b0;
            n_match    = 2'd0;
        end else if (i_cdata_mode) begin
            o_job.prefix = r_open ? SEG_NONE : SEG_OPEN;
            n_open       = 1'b1;
            if (i_char_code == ChBrack) begin
                n_match = (match == 2'd2) ? 2'd2 : match + 2'd1;
            end else if (i_char_code == ChGt && match == 2'd2) begin
                o_job.prefix = SEG_SPLIT;
                n_match      = 2'd0;
            end else begin
                n_match = 2'd0;
            end
        end else begin
            o_job.prefix = r_open ? SEG_CLOSE : SEG_NONE;
            n_open       = 1'b0;
            n_match      = 2'd0;
            case (i_char_code)
                ChAmp:   o_job.body = SEG_AMP;
                ChLt:    o_job.body = SEG_LT;
                ChGt:    o_job.body = SEG_GT;
                ChTab:   o_job.body = i_in_literal ? SEG_NUM9 : SEG_RAW;
                ChLf:    o_job.body = i_in_literal ? SEG_NUM10 : SEG_RAW;
                ChCr:    o_job.body = i_in_literal ? SEG_NUM13 : SEG_RAW;
                ChQuot:  o_job.body = i_in_literal ? SEG_QUOT : SEG_RAW;
                default: o_job.body = SEG_RAW;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_match <= 2'd0;
        end else if (accept) begin
            r_open  <= n_open;
            r_match <= n_match;
        end
    end

    a_match_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> r_match == 2'd0)
        else $error("partial match without open section");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_command |=> !r_open)
        else $error("section still open after close");

    a_split_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_job.prefix == SEG_SPLIT |-> r_open && r_match == 2'd2)
        else $error("split without full match");

endmodule

[design/xte_fifo.sv]
module xte_fifo import xte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[design/xte_back.sv]
module xte_back import xte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CharW-1:0] o_out_char,
    output logic             o_last_char
);

    logic             r_in_body;
    logic [IdxW-1:0]  r_idx;
    logic             r_out_valid;
    logic [CharW-1:0] r_out_char;
    logic             r_out_last;
    logic             in_prefix;
    t_seg             seg;
    logic             seg_end;
    logic             advance;
    logic [CharW-1:0] cur_char;

    assign in_prefix = (i_job.prefix != SEG_NONE) && !r_in_body;
    assign seg       = in_prefix ? i_job.prefix : i_job.body;
    assign seg_end   = (r_idx == seg_len(seg) - 4'd1);
    assign advance   = i_q_valid && (!r_out_valid || i_ready);
    assign cur_char  = (seg == SEG_RAW) ? i_job.ch : seg_char(seg, r_idx);
    assign o_pop     = advance && seg_end && !in_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (seg_end) begin
                    r_idx     <= '0;
                    r_in_body <= in_prefix;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= cur_char;
            r_out_last <= seg_end && !in_prefix;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx < seg_len(seg))
        else $error("segment index out of range");

    a_body_has_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid && r_in_body |-> i_job.prefix != SEG_NONE)
        else $error("body phase on a job without prefix");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_valid && o_last_char)
        else $error("job retired without a last character");

endmodule

[design/xml_text_escaper_top.sv]
// xml text escaper: takes one character (or a close command) per item and
// emits the xml text for it, one output character per result item, with
// o_last_char set on the final one. escape mode turns & < > into entities,
// and in attribute literal context also tab, lf, cr and the double quote.
// cdata mode wraps characters in a cdata section, opening one when needed
// and splitting it when a "]]>" would otherwise appear. a close command with
// no open section produces nothing. throughput: while the output is not
// stalled the back end emits one output character per cycle, and an item
// yields as many output characters as its expansion has (1 for plain text,
// up to 13 when a section is split); a two-entry job queue lets the front
// keep accepting items while the back drains an expansion. the output
// register holds a result until it is taken; while it waits the back end
// stalls and the queue absorbs up to two more jobs before the input stalls too.
module xml_text_escaper_top import xte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [CharW-1:0] i_char_code,
    input  logic             i_cdata_mode,
    input  logic             i_in_literal,
    // output channel
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CharW-1:0] o_out_char,
    output logic             o_last_char
);

    // front to queue
    logic push;
    t_job push_job;
    logic q_ready;
    // queue to back
    logic q_valid;
    t_job head_job;
    logic pop;

    // classifies each item and tracks section / match state
    xte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cdata_mode (i_cdata_mode),
        .i_in_literal (i_in_literal),
        .o_push       (push),
        .o_job        (push_job),
        .i_q_ready    (q_ready)
    );

    // short job queue decoupling classification from emission
    xte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    // walks the prefix and body segments one character per cycle while the output is not stalled
    xte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

import xte_pkg::*;

typedef enum bit {
    CMD_ENCODE,
    CMD_CLOSE
} t_cmd;

// one output character as the block should present it
typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
} t_xml_out;

// predicts the escaped text for each item and holds what is still due
class escaped_text_board;
    bit               sect_open;
    bit [1:0]         bracket_run;
    t_xml_out         chars_due[$];
    logic [CharW-1:0] item_chars[$];
    int               mismatches;

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            item_chars.push_back(CharW'(s[i]));
        end
    endfunction

    function void end_section();
        if (sect_open) begin
            add_text("]]>");
            sect_open   = 1'b0;
            bracket_run = 2'd0;
        end
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    function void note_item(t_cmd cmd, logic [CharW-1:0] ch, bit cdata, bit lit);
        item_chars.delete();
        if (cmd == CMD_CLOSE) begin
            end_section();
        end else if (cdata) begin
            if (!sect_open) begin
                add_text("<![CDATA[");
                sect_open   = 1'b1;
                bracket_run = 2'd0;
            end
            if (ch == ChBrack) begin
                if (bracket_run < 2'd2) bracket_run++;
            end else if (ch == ChGt && bracket_run == 2'd2) begin
                add_text("]]><![CDATA[");
                bracket_run = 2'd0;
            end else begin
                bracket_run = 2'd0;
            end
            item_chars.push_back(ch);
        end else begin
            end_section();
            case (ch)
                ChAmp:   add_text("&amp;");
                ChLt:    add_text("&lt;");
                ChGt:    add_text("&gt;");
                ChTab:   if (lit) add_text("&#9;"); else item_chars.push_back(ch);
                ChLf:    if (lit) add_text("&#10;"); else item_chars.push_back(ch);
                ChCr:    if (lit) add_text("&#13;"); else item_chars.push_back(ch);
                ChQuot:  if (lit) add_text("&quot;"); else item_chars.push_back(ch);
                default: item_chars.push_back(ch);
            endcase
        end
        foreach (item_chars[i]) begin
            chars_due.push_back('{item_chars[i], i == item_chars.size() - 1});
        end
    endfunction

    function void check_char(logic [CharW-1:0] ch, logic last);
        t_xml_out want;
        if (chars_due.size() == 0) begin
            flag($sformatf("unexpected char %h last %b", ch, last));
            return;
        end
        want = chars_due.pop_front();
        if (want.ch !== ch || want.last !== last) begin
            flag($sformatf("char exp %h got %h, last exp %b got %b",
                           want.ch, ch, want.last, last));
        end
    endfunction

    function void check_drained();
        if (chars_due.size() != 0) begin
            flag($sformatf("%0d output chars never arrived", chars_due.size()));
        end
    endfunction
endclass

module tb;

    // run length guards
    localparam int CycleLimit    = 400000;
    localparam int RandomItems   = 170;
    localparam int PressureHold  = 250;
    localparam int DrainCycles   = 32;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_ready;
    logic             i_command    = 1'b0;
    logic [CharW-1:0] i_char_code  = '0;
    logic             i_cdata_mode = 1'b0;
    logic             i_in_literal = 1'b0;
    logic             o_valid;
    logic             i_ready      = 1'b0;
    logic [CharW-1:0] o_out_char;
    logic             o_last_char;

    escaped_text_board board = new;

    // no_idle and hold_req are shared between the stimulus and the output side
    bit no_idle   = 1'b0;
    bit hold_req  = 1'b0;
    int items_sent;
    int cycles;

    xml_text_escaper_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cdata_mode (i_cdata_mode),
        .i_in_literal (i_in_literal),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    always #4 i_clk = ~i_clk;

    // watchdog: a correct run ends far below this
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // characters weighted toward the ones with special handling
    function automatic logic [CharW-1:0] any_char();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1, 2, 3: return ChBrack;
            4, 5:       return ChGt;
            6:          return ChAmp;
            7:          return ChLt;
            8:          return ChQuot;
            9:          return ChTab;
            10:         return ChLf;
            11:         return ChCr;
            12:         return CharW'($urandom);
            default:    return CharW'($urandom_range(32, 126));
        endcase
    endfunction

    // offer one item and hold it until the block takes it
    task automatic offer_item(input t_cmd cmd, input logic [CharW-1:0] ch,
                              input bit cdata, input bit lit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= ch;
        i_cdata_mode <= cdata;
        i_in_literal <= lit;
        // ready is settled mid-cycle, the item goes at the following edge
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        // a close with no section open produces nothing, so it is not counted
        if (cmd == CMD_ENCODE || board.sect_open) items_sent++;
        board.note_item(cmd, ch, cdata, lit);
    endtask

    // a char seen here mid-cycle is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && i_ready && o_valid) board.check_char(o_out_char, o_last_char);
    end

    // output side: random stalls, one long hold-off
    int stall_left;
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                // long hold-off so the block fills up and stalls its input
                hold_req  = 1'b0;
                hold_left = PressureHold;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                i_ready <= (stall_left == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  kind;
        int  len;
        bit  lit;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // escape mode: entities, literal context on and off, extreme codes
        offer_item(CMD_ENCODE, ChAmp, 1'b0, 1'b0);
        offer_item(CMD_ENCODE, ChLt, 1'b0, 1'b0);
        offer_item(CMD_ENCODE, ChGt, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, ChQuot, 1'b0, 1'b0);
        offer_item(CMD_ENCODE, ChQuot, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, ChTab, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, ChLf, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, ChCr, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, ChTab, 1'b0, 1'b0);
        offer_item(CMD_ENCODE, ChCr, 1'b0, 1'b0);
        offer_item(CMD_ENCODE, '1, 1'b0, 1'b1);
        offer_item(CMD_ENCODE, '0, 1'b0, 1'b0);
        // close while nothing is open: no output at all
        offer_item(CMD_CLOSE, '1, 1'b1, 1'b1);
        // cdata: open, three brackets keep the match at two, then the split
        offer_item(CMD_ENCODE, CharW'(8'h61), 1'b1, 1'b0);
        offer_item(CMD_ENCODE, ChBrack, 1'b1, 1'b0);
        offer_item(CMD_ENCODE, ChBrack, 1'b1, 1'b0);
        offer_item(CMD_ENCODE, ChBrack, 1'b1, 1'b0);
        offer_item(CMD_ENCODE, ChGt, 1'b1, 1'b0);
        // single bracket then '>' must not split
        offer_item(CMD_ENCODE, ChBrack, 1'b1, 1'b0);
        offer_item(CMD_ENCODE, ChGt, 1'b1, 1'b0);
        // escape-mode char closes the open section first
        offer_item(CMD_ENCODE, ChAmp, 1'b0, 1'b0);
        // literal flag has no effect in cdata; surrogate and out-of-range pass
        offer_item(CMD_ENCODE, ChQuot, 1'b1, 1'b1);
        offer_item(CMD_ENCODE, CharW'(21'h00d800), 1'b1, 1'b0);
        offer_item(CMD_ENCODE, CharW'(21'h110000), 1'b1, 1'b1);
        offer_item(CMD_CLOSE, '0, 1'b0, 1'b0);
        offer_item(CMD_CLOSE, '0, 1'b1, 1'b0);

        // random part starts under the long output hold-off
        hold_req   = 1'b1;
        items_sent = 0;
        while (items_sent < RandomItems) begin
            kind    = $urandom_range(0, 9);
            no_idle = ($urandom_range(0, 4) == 0);
            if (kind < 6) begin
                // cdata run, often ended by a close
                len = $urandom_range(1, 8);
                repeat (len) begin
                    offer_item(CMD_ENCODE, any_char(), 1'b1, 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 1) == 1) begin
                    offer_item(CMD_CLOSE, CharW'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
            end else if (kind < 9) begin
                // escaped text run in one context
                len = $urandom_range(1, 6);
                lit = 1'($urandom_range(0, 1));
                repeat (len) offer_item(CMD_ENCODE, any_char(), 1'b0, lit);
            end else begin
                // noise: every field random
                offer_item(t_cmd'($urandom_range(0, 1)), CharW'($urandom),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        // let every expected char come out, then a short quiet period
        while (board.chars_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        board.check_drained();

        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
design/xte_pkg.sv
design/xte_front.sv
design/xte_fifo.sv
design/xte_back.sv
design/xml_text_escaper_top.sv
tb/tb.sv
